// ----- hdl/kst_pkg.sv -----
`timescale 1ns / 1ps

package kst_pkg;

  // Operation codes on the kind field.
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_UPDATE = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_MAX    = 3'd3;
  localparam logic [2:0] KIND_COUNT  = 3'd4;

  // Outcome codes.
  localparam logic [2:0] OC_OK       = 3'd0;
  localparam logic [2:0] OC_FULL     = 3'd1;
  localparam logic [2:0] OC_DUP      = 3'd2;
  localparam logic [2:0] OC_NOTFOUND = 3'd3;
  localparam logic [2:0] OC_INVALID  = 3'd4;
  localparam logic [2:0] OC_EMPTY    = 3'd5;

  // Health codes.
  localparam logic [1:0] HEALTH_OK      = 2'd0;
  localparam logic [1:0] HEALTH_INVALID = 2'd3;

  // One stored sensor record.
  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] reading;
    logic [1:0]  health;
  } rec_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

// ----- hdl/kst_ram.sv -----
`timescale 1ns / 1ps

module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/keyed_sensor_table.sv -----
`timescale 1ns / 1ps

// Table of up to ENTRIES sensor records (id, signed reading, health) kept
// in one synchronous RAM in the order they were added. A word is accepted
// when start is high and busy is low; its result appears on the out_ ports
// for exactly one cycle, marked by out_valid, in the cycle after the work is
// done, and must be taken then since the receiver cannot stall the block.
// Words whose outcome follows from the fill count and the input fields
// alone (table full, invalid parameters, empty table, unused kinds) keep
// busy low and give their result in the next cycle. All other words scan
// the RAM one entry per cycle through its single read port, and busy stays
// high until every filled entry has been read and examined.
// Reset empties the table; there is no clearing pass.
module keyed_sensor_table #(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_sensor_key,
  input  logic signed [31:0] in_reading_in,
  input  logic [1:0]         in_health_in,
  output logic               out_valid,
  output logic [2:0]         out_outcome,
  output logic signed [31:0] out_reading_out,
  output logic [1:0]         out_health_out,
  output logic [3:0]         out_tally
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = $bits(kst_pkg::rec_t);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  kst_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic            rv_r, rv_nxt;
  logic [AW-1:0]   ridx_r, ridx_nxt;
  logic            found_r, found_nxt;
  logic [AW-1:0]   fidx_r, fidx_nxt;
  logic [31:0]     best_r, best_nxt;
  logic [1:0]      fhl_r, fhl_nxt;
  logic [3:0]      cnt_r, cnt_nxt;

  logic [2:0]      kind_r, kind_nxt;
  logic [7:0]      key_r, key_nxt;
  logic [31:0]     rd_r, rd_nxt;
  logic [1:0]      hl_r, hl_nxt;

  logic            ov_r, ov_nxt;
  logic [2:0]      oc_r, oc_nxt;
  logic [31:0]     ord_r, ord_nxt;
  logic [1:0]      ohl_r, ohl_nxt;
  logic [3:0]      otl_r, otl_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  kst_pkg::rec_t   wrec;
  kst_pkg::rec_t   rrec;
  logic [RW-1:0]   rdata;

  assign rrec  = kst_pkg::rec_t'(rdata);
  assign raddr = iss_r[AW-1:0];
  assign wrec  = '{key: key_r, reading: rd_r, health: hl_r};

  kst_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wrec),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequencer: early decisions, scan of the records, final result and write.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    iss_nxt   = iss_r;
    rv_nxt    = 1'b0;
    ridx_nxt  = ridx_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    best_nxt  = best_r;
    fhl_nxt   = fhl_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    rd_nxt    = rd_r;
    hl_nxt    = hl_r;
    ov_nxt    = 1'b0;
    oc_nxt    = oc_r;
    ord_nxt   = ord_r;
    ohl_nxt   = ohl_r;
    otl_nxt   = otl_r;
    we        = 1'b0;
    waddr     = fill_r[AW-1:0];

    unique case (state_r)
      kst_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          key_nxt   = in_sensor_key;
          rd_nxt    = in_reading_in;
          hl_nxt    = in_health_in;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          ord_nxt   = '0;
          ohl_nxt   = '0;
          otl_nxt   = '0;
          // Outcomes that need no scan are given at once.
          priority if (in_kind == kst_pkg::KIND_ADD && fill_r >= FULL_COUNT) begin
            ov_nxt = 1'b1;
            oc_nxt = kst_pkg::OC_FULL;
          end else if (in_kind == kst_pkg::KIND_ADD &&
                       (in_sensor_key == 8'd0 ||
                        in_health_in == kst_pkg::HEALTH_INVALID)) begin
            ov_nxt = 1'b1;
            oc_nxt = kst_pkg::OC_INVALID;
          end else if ((in_kind == kst_pkg::KIND_UPDATE ||
                        in_kind == kst_pkg::KIND_FIND ||
                        in_kind == kst_pkg::KIND_MAX) && fill_r == '0) begin
            ov_nxt = 1'b1;
            oc_nxt = kst_pkg::OC_EMPTY;
          end else if ((in_kind == kst_pkg::KIND_UPDATE ||
                        in_kind == kst_pkg::KIND_COUNT) &&
                       in_health_in == kst_pkg::HEALTH_INVALID) begin
            ov_nxt = 1'b1;
            oc_nxt = kst_pkg::OC_INVALID;
          end else if (in_kind == kst_pkg::KIND_ADD ||
                       in_kind == kst_pkg::KIND_UPDATE ||
                       in_kind == kst_pkg::KIND_FIND ||
                       in_kind == kst_pkg::KIND_MAX ||
                       in_kind == kst_pkg::KIND_COUNT) begin
            state_nxt = kst_pkg::ST_SCAN;
          end else begin
            ov_nxt = 1'b1;
            oc_nxt = kst_pkg::OC_INVALID;
          end
        end
      end

      kst_pkg::ST_SCAN: begin
        // Issue one read per cycle over the filled entries.
        if (iss_r < fill_r) begin
          iss_nxt  = iss_r + CW'(1);
          rv_nxt   = 1'b1;
          ridx_nxt = iss_r[AW-1:0];
        end

        // Examine the record that the previous read returned.
        if (rv_r) begin
          unique case (kind_r)
            kst_pkg::KIND_MAX: begin
              if (rrec.health == kst_pkg::HEALTH_OK &&
                  (!found_r || $signed(rrec.reading) > $signed(best_r))) begin
                found_nxt = 1'b1;
                best_nxt  = rrec.reading;
              end
            end
            kst_pkg::KIND_COUNT: begin
              if (rrec.health == hl_r) begin
                cnt_nxt = cnt_r + 4'd1;
              end
            end
            default: begin
              // Add, update and find keep the first record with the key.
              if (rrec.key == key_r && !found_r) begin
                found_nxt = 1'b1;
                fidx_nxt  = ridx_r;
                best_nxt  = rrec.reading;
                fhl_nxt   = rrec.health;
              end
            end
          endcase
        end

        // All entries seen: give the result and commit any write.
        if (!(iss_r < fill_r) && !rv_r) begin
          state_nxt = kst_pkg::ST_IDLE;
          ov_nxt    = 1'b1;
          oc_nxt    = kst_pkg::OC_OK;
          unique case (kind_r)
            kst_pkg::KIND_ADD: begin
              if (found_r) begin
                oc_nxt = kst_pkg::OC_DUP;
              end else begin
                we       = 1'b1;
                waddr    = fill_r[AW-1:0];
                fill_nxt = fill_r + CW'(1);
              end
            end
            kst_pkg::KIND_UPDATE: begin
              if (found_r) begin
                we    = 1'b1;
                waddr = fidx_r;
              end else begin
                oc_nxt = kst_pkg::OC_NOTFOUND;
              end
            end
            kst_pkg::KIND_FIND: begin
              if (found_r) begin
                ord_nxt = best_r;
                ohl_nxt = fhl_r;
              end else begin
                oc_nxt = kst_pkg::OC_NOTFOUND;
              end
            end
            kst_pkg::KIND_MAX: begin
              if (found_r) begin
                ord_nxt = best_r;
              end else begin
                oc_nxt = kst_pkg::OC_NOTFOUND;
              end
            end
            default: begin
              otl_nxt = cnt_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = kst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kst_pkg::ST_IDLE;
      fill_r  <= '0;
      iss_r   <= '0;
      rv_r    <= 1'b0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      iss_r   <= iss_nxt;
      rv_r    <= rv_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Operands, scan results and output word.
  always_ff @(posedge clk) begin
    ridx_r <= ridx_nxt;
    fidx_r <= fidx_nxt;
    best_r <= best_nxt;
    fhl_r  <= fhl_nxt;
    cnt_r  <= cnt_nxt;
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    rd_r   <= rd_nxt;
    hl_r   <= hl_nxt;
    oc_r   <= oc_nxt;
    ord_r  <= ord_nxt;
    ohl_r  <= ohl_nxt;
    otl_r  <= otl_nxt;
  end

  assign busy            = (state_r != kst_pkg::ST_IDLE);
  assign out_valid       = ov_r;
  assign out_outcome     = oc_r;
  assign out_reading_out = ord_r;
  assign out_health_out  = ohl_r;
  assign out_tally       = otl_r;

endmodule

// ----- tb/sv/tb_keyed_sensor_table.sv -----
`timescale 1ns / 1ps

module tb_keyed_sensor_table;

  localparam int ENTRIES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_PHASE = 140;
  localparam int SCRIPT_ROWS = 25;
  localparam int MAX_GAP = 40;
  localparam int REPORT_LIMIT = 10;

  // Kind values that the block does not implement.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Health values besides ok and invalid.
  localparam logic [1:0] HEALTH_DISCONNECTED = 2'd1;
  localparam logic [1:0] HEALTH_OUT_OF_BOUNDS = 2'd2;

  // An outcome the block never gives; it marks a script row whose reply
  // comes from the table model instead of being typed in.
  localparam logic [2:0] OC_UNTYPED = 3'd7;

  typedef struct packed {
    logic [2:0]         outcome;
    logic signed [31:0] reading;
    logic [1:0]         health;
    logic [3:0]         tally;
  } sensor_reply_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         key;
    logic signed [31:0] reading;
    logic [1:0]         health;
    sensor_reply_t      reply;
  } script_row_t;

  localparam sensor_reply_t NO_TYPED_REPLY = {OC_UNTYPED, 38'd0};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_kind = '0;
  logic [7:0]         in_sensor_key = '0;
  logic signed [31:0] in_reading_in = '0;
  logic [1:0]         in_health_in = '0;
  logic               out_valid;
  logic [2:0]         out_outcome;
  logic signed [31:0] out_reading_out;
  logic [1:0]         out_health_out;
  logic [3:0]         out_tally;

  keyed_sensor_table #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_sensor_key(in_sensor_key),
    .in_reading_in(in_reading_in),
    .in_health_in(in_health_in),
    .out_valid(out_valid),
    .out_outcome(out_outcome),
    .out_reading_out(out_reading_out),
    .out_health_out(out_health_out),
    .out_tally(out_tally)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the sensor table, updated as each word is accepted.
  logic [7:0]         key_tbl [ENTRIES];
  logic signed [31:0] reading_tbl [ENTRIES];
  logic [1:0]         health_tbl [ENTRIES];
  int                 fill = 0;

  sensor_reply_t pending_replies [$];
  script_row_t   script [SCRIPT_ROWS];

  int cycle_count = 0;
  int words_sent = 0;
  int replies_checked = 0;
  int mismatches = 0;
  int unexpected_replies = 0;
  int full_refusals = 0;
  int kind_seen [8] = '{default: 0};

  // Index of the oldest record with this id, or -1 when there is none.
  function automatic int find_slot(input logic [7:0] key);
    int i;
    for (i = 0; i < fill; i++)
      if (key_tbl[i] == key)
        return i;
    return -1;
  endfunction

  // Applies one word to the shadow table and returns the reply it earns.
  function automatic sensor_reply_t apply_word(input logic [2:0] kind,
                                               input logic [7:0] key,
                                               input logic signed [31:0] rd,
                                               input logic [1:0] hl);
    sensor_reply_t r;
    int idx;
    int i;
    bit seen;
    r = '0;
    r.outcome = kst_pkg::OC_OK;
    case (kind)
      kst_pkg::KIND_ADD: begin
        if (fill >= ENTRIES)
          r.outcome = kst_pkg::OC_FULL;
        else if (key == 8'd0 || hl == kst_pkg::HEALTH_INVALID)
          r.outcome = kst_pkg::OC_INVALID;
        else if (find_slot(key) >= 0)
          r.outcome = kst_pkg::OC_DUP;
        else begin
          key_tbl[fill] = key;
          reading_tbl[fill] = rd;
          health_tbl[fill] = hl;
          fill++;
        end
      end
      kst_pkg::KIND_UPDATE: begin
        idx = find_slot(key);
        if (fill == 0)
          r.outcome = kst_pkg::OC_EMPTY;
        else if (hl == kst_pkg::HEALTH_INVALID)
          r.outcome = kst_pkg::OC_INVALID;
        else if (idx < 0)
          r.outcome = kst_pkg::OC_NOTFOUND;
        else begin
          reading_tbl[idx] = rd;
          health_tbl[idx] = hl;
        end
      end
      kst_pkg::KIND_FIND: begin
        idx = find_slot(key);
        if (fill == 0)
          r.outcome = kst_pkg::OC_EMPTY;
        else if (idx < 0)
          r.outcome = kst_pkg::OC_NOTFOUND;
        else begin
          r.reading = reading_tbl[idx];
          r.health = health_tbl[idx];
        end
      end
      kst_pkg::KIND_MAX: begin
        if (fill == 0)
          r.outcome = kst_pkg::OC_EMPTY;
        else begin
          // Largest signed reading among records whose health is ok.
          seen = 1'b0;
          for (i = 0; i < fill; i++)
            if (health_tbl[i] == kst_pkg::HEALTH_OK &&
                (!seen || $signed(reading_tbl[i]) > $signed(r.reading))) begin
              r.reading = reading_tbl[i];
              seen = 1'b1;
            end
          if (!seen) begin
            r.outcome = kst_pkg::OC_NOTFOUND;
            r.reading = '0;
          end
        end
      end
      kst_pkg::KIND_COUNT: begin
        if (hl == kst_pkg::HEALTH_INVALID)
          r.outcome = kst_pkg::OC_INVALID;
        else
          for (i = 0; i < fill; i++)
            if (health_tbl[i] == hl)
              r.tally = r.tally + 4'd1;
      end
      default: r.outcome = kst_pkg::OC_INVALID;
    endcase
    return r;
  endfunction

  function automatic script_row_t row(input logic [2:0] kind, input logic [7:0] key,
                                      input logic [31:0] rd, input logic [1:0] hl,
                                      input logic [2:0] oc, input logic [31:0] rd_out,
                                      input logic [1:0] hl_out, input logic [3:0] tl);
    script_row_t s;
    s.kind = kind;
    s.key = key;
    s.reading = rd;
    s.health = hl;
    s.reply.outcome = oc;
    s.reply.reading = rd_out;
    s.reply.health = hl_out;
    s.reply.tally = tl;
    return s;
  endfunction

  // Presents one word after a random idle gap and holds it until accepted.
  task automatic send_word(input logic [2:0] kind, input logic [7:0] key,
                           input logic signed [31:0] rd, input logic [1:0] hl,
                           input sensor_reply_t typed, input int idle_pct);
    sensor_reply_t predicted;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_sensor_key <= key;
    in_reading_in <= rd;
    in_health_in <= hl;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_word(kind, key, rd, hl);
    if (predicted.outcome == kst_pkg::OC_FULL)
      full_refusals++;
    pending_replies.push_back(typed.outcome == OC_UNTYPED ? predicted : typed);
    words_sent++;
    kind_seen[kind]++;
  endtask

  // Builds a mostly well-formed word: ids usually taken from the table.
  task automatic send_random_word(input int idle_pct);
    logic [2:0]         kind;
    logic [7:0]         key;
    logic signed [31:0] rd;
    logic [1:0]         hl;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12)
      kind = kst_pkg::KIND_ADD;
    else if (pick < 34)
      kind = kst_pkg::KIND_UPDATE;
    else if (pick < 58)
      kind = kst_pkg::KIND_FIND;
    else if (pick < 72)
      kind = kst_pkg::KIND_MAX;
    else if (pick < 92)
      kind = kst_pkg::KIND_COUNT;
    else
      kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));

    pick = $urandom_range(99);
    if (kind == kst_pkg::KIND_ADD) begin
      if (pick < 10)
        key = 8'd0;
      else if (pick < 30 && fill > 0)
        key = key_tbl[$urandom_range(fill - 1)];
      else
        key = 8'($urandom_range(1, 255));
    end else if (pick < 65 && fill > 0)
      key = key_tbl[$urandom_range(fill - 1)];
    else
      key = 8'($urandom_range(0, 255));

    hl = ($urandom_range(99) < 8) ? kst_pkg::HEALTH_INVALID : 2'($urandom_range(0, 2));

    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0: rd = 32'sh7FFF_FFFF;
        1: rd = 32'sh8000_0000;
        2: rd = 32'sd0;
        default: rd = -32'sd1;
      endcase
    end else
      rd = $urandom;

    send_word(kind, key, rd, hl, NO_TYPED_REPLY, idle_pct);
  endtask

  // Stops sending and waits until every outstanding reply has come back.
  task automatic wait_for_replies;
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Reply checker: each strobed word is compared with the oldest prediction.
  always @(posedge clk) begin
    sensor_reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        unexpected_replies++;
        if (mismatches + unexpected_replies <= REPORT_LIMIT)
          $display("tb: reply with nothing outstanding: outcome %0d reading %0d",
                   out_outcome, out_reading_out);
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (out_outcome !== want.outcome || out_reading_out !== want.reading ||
            out_health_out !== want.health || out_tally !== want.tally) begin
          mismatches++;
          if (mismatches + unexpected_replies <= REPORT_LIMIT) begin
            $write("tb: reply %0d differs: outcome %0d/%0d reading %0d/%0d ",
                   replies_checked, want.outcome, out_outcome, want.reading,
                   out_reading_out);
            $display("health %0d/%0d tally %0d/%0d (expected/actual)",
                     want.health, out_health_out, want.tally, out_tally);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    int phase;
    int idle_pct;

    // Directed words: empty-table cases, bad parameters, unused kinds,
    // extreme ids and readings, duplicates and a max with no ok record.
    script[0]  = row(kst_pkg::KIND_FIND,   8'd5,   32'd0,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_EMPTY, 32'd0, 2'd0, 4'd0);
    script[1]  = row(kst_pkg::KIND_MAX,    8'd0,   32'd0,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_EMPTY, 32'd0, 2'd0, 4'd0);
    script[2]  = row(kst_pkg::KIND_UPDATE, 8'd5,   32'd1,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_EMPTY, 32'd0, 2'd0, 4'd0);
    script[3]  = row(kst_pkg::KIND_COUNT,  8'd0,   32'd0,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_OK, 32'd0, 2'd0, 4'd0);
    script[4]  = row(kst_pkg::KIND_COUNT,  8'd0,   32'd0,         kst_pkg::HEALTH_INVALID,
                     kst_pkg::OC_INVALID, 32'd0, 2'd0, 4'd0);
    script[5]  = row(kst_pkg::KIND_ADD,    8'd0,   32'd1,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_INVALID, 32'd0, 2'd0, 4'd0);
    script[6]  = row(kst_pkg::KIND_ADD,    8'd9,   32'd1,         kst_pkg::HEALTH_INVALID,
                     kst_pkg::OC_INVALID, 32'd0, 2'd0, 4'd0);
    script[7]  = row(KIND_SPARE_LO, 8'd1, 32'd1,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_INVALID, 32'd0, 2'd0, 4'd0);
    script[8]  = row(KIND_SPARE_HI, 8'hFF, 32'hFFFF_FFFF, kst_pkg::HEALTH_INVALID,
                     kst_pkg::OC_INVALID, 32'd0, 2'd0, 4'd0);
    script[9]  = row(kst_pkg::KIND_ADD,    8'hFF,  32'h7FFF_FFFF, kst_pkg::HEALTH_OK,
                     kst_pkg::OC_OK, 32'd0, 2'd0, 4'd0);
    script[10] = row(kst_pkg::KIND_ADD,    8'd1,   32'h8000_0000, kst_pkg::HEALTH_OK,
                     kst_pkg::OC_OK, 32'd0, 2'd0, 4'd0);
    script[11] = row(kst_pkg::KIND_ADD,    8'hFF,  32'd0,         HEALTH_DISCONNECTED,
                     kst_pkg::OC_DUP, 32'd0, 2'd0, 4'd0);
    script[12] = row(kst_pkg::KIND_FIND,   8'hFF,  32'd0,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_OK, 32'h7FFF_FFFF, kst_pkg::HEALTH_OK, 4'd0);
    script[13] = row(kst_pkg::KIND_MAX,    8'd0,   32'd0,         kst_pkg::HEALTH_OK,
                     kst_pkg::OC_OK, 32'h7FFF_FFFF, 2'd0, 4'd0);
    script[14] = row(kst_pkg::KIND_UPDATE, 8'hFF,  32'd3,         kst_pkg::HEALTH_INVALID,
                     kst_pkg::OC_INVALID, 32'd0, 2'd0, 4'd0);
    script[15] = row(kst_pkg::KIND_UPDATE, 8'd77,  32'd3,         kst_pkg::HEALTH_OK,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[16] = row(kst_pkg::KIND_FIND,   8'd77,  32'd0,         kst_pkg::HEALTH_OK,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[17] = row(kst_pkg::KIND_UPDATE, 8'hFF,  -32'sd5,       HEALTH_OUT_OF_BOUNDS,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[18] = row(kst_pkg::KIND_MAX,    8'd0,   32'd0,         kst_pkg::HEALTH_OK,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[19] = row(kst_pkg::KIND_UPDATE, 8'd1,   32'd0,         HEALTH_DISCONNECTED,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[20] = row(kst_pkg::KIND_MAX,    8'd0,   32'd0,         kst_pkg::HEALTH_OK,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[21] = row(kst_pkg::KIND_COUNT,  8'd0,   32'd0,         HEALTH_DISCONNECTED,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[22] = row(kst_pkg::KIND_COUNT,  8'd0,   32'd0,         HEALTH_OUT_OF_BOUNDS,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[23] = row(kst_pkg::KIND_ADD,    8'h80,  32'hAAAA_5555, HEALTH_OUT_OF_BOUNDS,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);
    script[24] = row(kst_pkg::KIND_FIND,   8'd1,   32'd0,         kst_pkg::HEALTH_OK,
                     OC_UNTYPED, 32'd0, 2'd0, 4'd0);

    // Single reset at the start of the run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < SCRIPT_ROWS; n++)
      send_word(script[n].kind, script[n].key, script[n].reading, script[n].health,
                script[n].reply, 0);
    wait_for_replies();

    // Random words in phases of differing sender idling; the table fills
    // early on, after which adds are refused as full.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 69;
        3: idle_pct = 12;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < WORDS_PER_PHASE; n++)
        send_random_word(idle_pct);
      wait_for_replies();
    end

    // Let any stray reply show up before the verdict.
    repeat (20) @(posedge clk);

    $write("tb: %0d words sent (add %0d, update %0d, find %0d, max %0d, ",
           words_sent, kind_seen[kst_pkg::KIND_ADD], kind_seen[kst_pkg::KIND_UPDATE],
           kind_seen[kst_pkg::KIND_FIND], kind_seen[kst_pkg::KIND_MAX]);
    $display("count %0d, unused kind %0d), %0d replies checked",
             kind_seen[kst_pkg::KIND_COUNT],
             words_sent - kind_seen[kst_pkg::KIND_ADD] - kind_seen[kst_pkg::KIND_UPDATE] -
             kind_seen[kst_pkg::KIND_FIND] - kind_seen[kst_pkg::KIND_MAX] -
             kind_seen[kst_pkg::KIND_COUNT],
             replies_checked);
    $display("tb: table held %0d of %0d records, %0d adds refused as full",
             fill, ENTRIES, full_refusals);
    if (mismatches == 0 && unexpected_replies == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d unexpected, %0d missing replies",
               mismatches, unexpected_replies, pending_replies.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
